### src/tick_task_scheduler_macros.svh
// assertion macros shared by the scheduler rtl
`ifndef TICK_TASK_SCHEDULER_MACROS_SVH
`define TICK_TASK_SCHEDULER_MACROS_SVH

// property checked at every clock edge outside reset
`define TTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition in one cycle implies a property in the next
`define TTS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### src/tts_pkg.sv
// types and constants of the tick task scheduler
`timescale 1ns / 1ps

package tts_pkg;

  // input modes
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_DISP = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;

  // field widths
  localparam int unsigned CountW = 13;
  localparam int unsigned PendW  = 8;
  localparam int unsigned MsW    = 16;
  localparam int unsigned SlotW  = 3;

  // most results one dispatch may produce
  localparam int unsigned MaxOut = 8;
  localparam logic [PendW-1:0] PendMax = 8'hFF;

  // divide by ten: x * 52429 >> 19 is exact for 16 bit x
  localparam int unsigned Div10MulW = 17;
  localparam logic [Div10MulW-1:0] Div10Mul = 17'd52429;
  localparam int unsigned Div10Shift = 19;
  localparam int unsigned ProdW = MsW + Div10MulW;

  // one task table entry
  typedef struct packed {
    logic [CountW-1:0] countdown;
    logic [CountW-1:0] period;
    logic [PendW-1:0]  pending;
  } entry_t;

endpackage

### src/tick_task_scheduler.sv
// tick task scheduler: task table in a synchronous memory with a slot walker
//
// Input channel (in_valid_i / in_stall_o) takes one item: mode_i selects add,
// tick or dispatch; delay_ms_i and period_ms_i matter for add only. Output
// channel (out_valid_o / out_stall_i) gives results kind_o, slot_o, last_o.
// An add gives one result (task added with its slot, or table full), a tick
// gives none, a dispatch gives one result per slot with pending runs, at most
// eight, the final one with last_o set. Mode three is taken and ignored.
// Slots fill in order and are never freed, so a fill count marks valid slots.
// An add runs the divide by ten multiply, the memory write, then the result.
// Tick and dispatch walk the filled slots through the single table memory,
// one slot per cycle unless a dispatch walk is paused, with read and write
// back overlapped. The next item is taken once the last result of the
// current one sits in the output register; a stalled output holds its result
// and pauses a dispatch walk only when a second result is ready to leave.
// Reset (rst_ni low) empties the table and drops any result in flight; the
// memory itself is not cleared since only filled slots are ever read.
`timescale 1ns / 1ps
`include "tick_task_scheduler_macros.svh"

module tick_task_scheduler #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] delay_ms_i,
  input  logic [15:0] period_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  slot_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(TASK_SLOTS + 1);
  localparam int unsigned SlotW = tts_pkg::SlotW;
  localparam int unsigned NW = $clog2(tts_pkg::MaxOut + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic p_valid_q, p_valid_d;
  logic [IdxW-1:0] p_idx_q, p_idx_d;
  logic walk_disp_q, walk_disp_d;
  logic [NW-1:0] n_q, n_d;
  logic hold_valid_q, hold_valid_d;
  logic [1:0] hold_kind_q, hold_kind_d;
  logic [SlotW-1:0] hold_slot_q, hold_slot_d;
  logic out_valid_q;
  logic [1:0] out_kind_q;
  logic [SlotW-1:0] out_slot_q;
  logic out_last_q;
  logic [tts_pkg::ProdW-1:0] dly_prod_q, per_prod_q;

  // table memory
  tts_pkg::entry_t mem_q [TASK_SLOTS];
  tts_pkg::entry_t rd_q;
  tts_pkg::entry_t wdata;
  logic rd_en, wr_en;
  logic [IdxW-1:0] raddr, waddr;

  logic accept, out_free, table_full;
  logic emit, emit_last;
  logic found, block, advance;
  logic [tts_pkg::CountW-1:0] cd_dec;
  tts_pkg::entry_t tick_ent;
  logic [IdxW+SlotW-1:0] p_ext;
  logic [CntW+SlotW-1:0] fill_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign table_full = (fill_q == CntW'(TASK_SLOTS));

  // slot indexes masked to the 3 bit result field
  assign p_ext    = {{SlotW{1'b0}}, p_idx_q};
  assign fill_ext = {{SlotW{1'b0}}, fill_q};

  // tick update of the entry under the walker
  always_comb begin
    tick_ent = rd_q;
    cd_dec   = rd_q.countdown - 1'b1;
    if (rd_q.countdown != '0) begin
      tick_ent.countdown = cd_dec;
      if (cd_dec == '0) begin
        tick_ent.countdown = rd_q.period;
        if (rd_q.pending != tts_pkg::PendMax) begin
          tick_ent.pending = rd_q.pending + 1'b1;
        end
      end
    end
  end

  // dispatch: slot with pending work, within the result budget
  assign found = (state_q == ST_WALK) && p_valid_q && walk_disp_q &&
                 (rd_q.pending != '0) && (n_q < NW'(tts_pkg::MaxOut));
  assign block   = found && hold_valid_q && !out_free;
  assign advance = !block;

  // memory port control
  always_comb begin
    rd_en = 1'b0;
    wr_en = 1'b0;
    raddr = rd_cnt_q[IdxW-1:0];
    waddr = p_idx_q;
    wdata = tick_ent;
    unique case (state_q)
      ST_ADD: begin
        wr_en = 1'b1;
        waddr = fill_q[IdxW-1:0];
        wdata.countdown = dly_prod_q[tts_pkg::Div10Shift +: tts_pkg::CountW] + 1'b1;
        wdata.period    = per_prod_q[tts_pkg::Div10Shift +: tts_pkg::CountW];
        wdata.pending   = '0;
      end
      ST_WALK: begin
        rd_en = advance && (rd_cnt_q < fill_q);
        if (walk_disp_q) begin
          wdata.countdown = rd_q.countdown;
          wdata.period    = rd_q.period;
          wdata.pending   = rd_q.pending - 1'b1;
          wr_en = found && advance;
        end else begin
          wr_en = p_valid_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem_q[raddr];
    end
  end

  // divide by ten products for an add
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dly_prod_q <= tts_pkg::ProdW'(delay_ms_i) * tts_pkg::ProdW'(tts_pkg::Div10Mul);
      per_prod_q <= tts_pkg::ProdW'(period_ms_i) * tts_pkg::ProdW'(tts_pkg::Div10Mul);
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    rd_cnt_d     = rd_cnt_q;
    p_valid_d    = p_valid_q;
    p_idx_d      = p_idx_q;
    walk_disp_d  = walk_disp_q;
    n_d          = n_q;
    hold_valid_d = hold_valid_q;
    hold_kind_d  = hold_kind_q;
    hold_slot_d  = hold_slot_q;
    emit         = 1'b0;
    emit_last    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (mode_i == tts_pkg::MODE_ADD) begin
            if (table_full) begin
              hold_valid_d = 1'b1;
              hold_kind_d  = tts_pkg::KIND_FULL;
              hold_slot_d  = '0;
              state_d      = ST_FIN;
            end else begin
              state_d = ST_ADD;
            end
          end else if (mode_i == tts_pkg::MODE_TICK || mode_i == tts_pkg::MODE_DISP) begin
            walk_disp_d = (mode_i == tts_pkg::MODE_DISP);
            rd_cnt_d    = '0;
            p_valid_d   = 1'b0;
            n_d         = '0;
            state_d     = ST_WALK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ADD: begin
        hold_valid_d = 1'b1;
        hold_kind_d  = tts_pkg::KIND_ADDED;
        hold_slot_d  = fill_ext[SlotW-1:0];
        fill_d       = fill_q + 1'b1;
        state_d      = ST_FIN;
      end
      ST_WALK: begin
        if (advance) begin
          if (found) begin
            emit         = hold_valid_q;
            hold_valid_d = 1'b1;
            hold_kind_d  = tts_pkg::KIND_RUN;
            hold_slot_d  = p_ext[SlotW-1:0];
            n_d          = n_q + 1'b1;
          end
          p_valid_d = rd_en;
          p_idx_d   = rd_cnt_q[IdxW-1:0];
          if (rd_en) begin
            rd_cnt_d = rd_cnt_q + 1'b1;
          end else if (!p_valid_q) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!hold_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          emit         = 1'b1;
          emit_last    = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      rd_cnt_q     <= '0;
      p_valid_q    <= 1'b0;
      walk_disp_q  <= 1'b0;
      n_q          <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      rd_cnt_q     <= rd_cnt_d;
      p_valid_q    <= p_valid_d;
      walk_disp_q  <= walk_disp_d;
      n_q          <= n_d;
      hold_valid_q <= hold_valid_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_idx_q     <= p_idx_d;
    hold_kind_q <= hold_kind_d;
    hold_slot_q <= hold_slot_d;
    if (out_free && emit) begin
      out_kind_q <= hold_kind_q;
      out_slot_q <= hold_slot_q;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign slot_o      = out_slot_q;
  assign last_o      = out_last_q;

  // checks
  `TTS_ASSERT(a_fill_range, fill_q <= CntW'(TASK_SLOTS), "fill count beyond table size")
  `TTS_ASSERT(a_walk_range, (state_q != ST_WALK) || (rd_cnt_q <= fill_q), "walker past fill")
  `TTS_ASSERT(a_budget, n_q <= NW'(tts_pkg::MaxOut),
              "dispatch result budget exceeded")
  `TTS_ASSERT(a_single_last,
              !out_valid_q || out_kind_q == tts_pkg::KIND_RUN || out_last_q,
              "add result without last")
  `TTS_ASSERT_NEXT(a_add_fill, state_q == ST_ADD, fill_q == $past(fill_q) + 1'b1,
                   "add did not take a slot")

endmodule
